>>> rtl/core/fbm_pkg.sv
// Shared types, codes and default sizes for the flash block map controller.
`default_nettype none

package fbm_pkg;

    // Default geometry
    localparam int DEF_PAGES_PER_BLK = 4;
    localparam int DEF_DATA_BLOCKS   = 16;

    // Field widths of the stream items
    localparam int SECTOR_W = 6;
    localparam int OP_W     = 3;
    localparam int PAGE_W   = 7;
    localparam int ERASE_W  = 5;
    localparam int STATUS_W = 2;

    // Packed stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = OP_W + STATUS_W;

    // Flash command codes
    typedef enum logic [OP_W-1:0] {
        OP_READ    = 3'd0,
        OP_PROGRAM = 3'd1,
        OP_COPY    = 3'd2,
        OP_ERASE   = 3'd3,
        OP_NONE    = 3'd4
    } op_t;

    // Request status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_UNMAPPED = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_BASE,
        S_COPY,
        S_PROG,
        S_ERASE
    } state_t;

    // One result beat
    typedef struct packed {
        op_t                 op;
        logic [PAGE_W-1:0]   target_page;
        logic [PAGE_W-1:0]   source_page;
        logic [ERASE_W-1:0]  erase_block;
        status_t             status;
        logic                last;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/flash_block_map_controller.sv
// Block-mapping flash translation controller: sequencer, map tables and page-written bits.
// A read, a single program or an error is decoded in S_DECIDE from the registered request
// and then held in the output register. An overwrite runs decode, base address, one page slot a
// cycle in the copy walk unless a copy beat waits on the output, then program and erase; one
// shared multiply-add forms the block bases and single-page addresses. Throughput: one request
// at a time; the next is taken once the last result is in the output register.
// Reset: all blocks unmapped, all pages erased, spare block 0, next unused block 1; no sweep.
`default_nettype none

module flash_block_map_controller
    import fbm_pkg::*;
#(
    parameter int PAGES_PER_BLK = DEF_PAGES_PER_BLK,
    parameter int DATA_BLOCKS   = DEF_DATA_BLOCKS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [5:0] sector_number, [7:6] zero
    input  wire logic                 s_tuser,   // [0] cmd

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [6:0] target_page, [13:7] source_page,
                                                 // [18:14] erase_block, [23:19] zero
    output logic [M_TUSER_W-1:0]      m_tuser,   // [2:0] op, [4:3] status
    output logic                      m_tlast
);

    // Geometry reachable through a six-bit sector number
    localparam int SECTORS   = 2 ** SECTOR_W;
    localparam int SPAN_BLKS = (SECTORS + PAGES_PER_BLK - 1) / PAGES_PER_BLK;
    localparam int LOG_BLKS  = (DATA_BLOCKS < SPAN_BLKS) ? DATA_BLOCKS : SPAN_BLKS;
    localparam int USED_BLKS = LOG_BLKS + 1;
    localparam int LBN_W     = $clog2(LOG_BLKS);
    localparam int OFF_W     = $clog2(PAGES_PER_BLK);
    localparam int PBN_W     = $clog2(USED_BLKS);
    localparam int NXT_W     = $clog2(USED_BLKS + 1);
    localparam int NUM_SECT  = DATA_BLOCKS * PAGES_PER_BLK;
    localparam logic [31:0]      PHYS_BLKS = 32'(DATA_BLOCKS + 1);
    localparam logic [OFF_W-1:0] LAST_IDX  = OFF_W'(PAGES_PER_BLK - 1);
    localparam int PAD_W     = M_TDATA_W - 2 * PAGE_W - ERASE_W;

    // Sector split tables
    function automatic logic [SECTORS-1:0][LBN_W-1:0] build_lbn_tab();
        logic [SECTORS-1:0][LBN_W-1:0] t;
        t = '0;
        for (int s = 0; s < SECTORS; s++)
        begin
            if (s < NUM_SECT)
            begin
                t[s] = LBN_W'(s / PAGES_PER_BLK);
            end
        end
        return t;
    endfunction

    function automatic logic [SECTORS-1:0][OFF_W-1:0] build_off_tab();
        logic [SECTORS-1:0][OFF_W-1:0] t;
        t = '0;
        for (int s = 0; s < SECTORS; s++)
        begin
            t[s] = OFF_W'(s % PAGES_PER_BLK);
        end
        return t;
    endfunction

    localparam logic [SECTORS-1:0][LBN_W-1:0] LBN_TAB = build_lbn_tab();
    localparam logic [SECTORS-1:0][OFF_W-1:0] OFF_TAB = build_off_tab();

    // State
    state_t                                  state_reg, state_next;
    logic [LOG_BLKS-1:0]                     map_valid_reg;
    logic [LOG_BLKS-1:0][PBN_W-1:0]          map_block_reg;
    logic [USED_BLKS-1:0][PAGES_PER_BLK-1:0] pw_reg;
    logic [PBN_W-1:0]                        spare_reg;
    logic [NXT_W-1:0]                        nxt_reg;

    // Request and walk registers
    logic                     cmd_reg;
    logic                     range_reg;
    logic [LBN_W-1:0]         lbn_reg;
    logic [OFF_W-1:0]         off_reg;
    logic [PBN_W-1:0]         pbn_reg;
    logic [PAGES_PER_BLK-1:0] row_reg;
    logic [PAGE_W-1:0]        pbase_reg;
    logic [PAGE_W-1:0]        sbase_reg;
    logic [OFF_W-1:0]         idx_reg;

    // Output register
    logic    out_valid_reg;
    result_t out_reg;

    // Control from the sequencer
    logic             accept;
    logic             can_emit;
    logic             emit;
    result_t          res;
    logic             pw_set_en;
    logic [PBN_W-1:0] pw_set_row;
    logic [OFF_W-1:0] pw_set_col;
    logic             pw_clr_en;
    logic             map_wr_en;
    logic             map_set_valid;
    logic [PBN_W-1:0] map_wr_val;
    logic             nxt_inc;
    logic             spare_wr;
    logic             latch_ow;
    logic             latch_sbase;
    logic             idx_adv;

    // Lookups for the current request
    logic                     mv;
    logic [PBN_W-1:0]         mb;
    logic [PAGES_PER_BLK-1:0] mrow;
    logic                     ow;
    logic                     copy_hit;
    logic [PBN_W-1:0]         new_pbn;

    // Shared page address unit: block times pages per block plus page
    logic [PBN_W-1:0]  au_blk;
    logic [OFF_W-1:0]  au_pg;
    logic [PAGE_W-1:0] au_addr;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign can_emit = !out_valid_reg || m_tready;

    assign mv       = map_valid_reg[lbn_reg];
    assign mb       = map_block_reg[lbn_reg];
    assign mrow     = pw_reg[mb];
    assign ow       = !range_reg && cmd_reg && mv && mrow[off_reg];
    assign new_pbn  = PBN_W'(nxt_reg);
    assign copy_hit = (idx_reg != off_reg) && row_reg[idx_reg];

    // Select operands of the address unit
    always_comb
    begin
        au_blk = mb;
        au_pg  = off_reg;
        if (state_reg == S_BASE)
        begin
            au_blk = spare_reg;
            au_pg  = '0;
        end
        else if (cmd_reg && !mv)
        begin
            au_blk = new_pbn;
        end
        else if (ow)
        begin
            au_pg = '0;
        end
    end

    assign au_addr = PAGE_W'(au_blk) * PAGE_W'(PAGES_PER_BLK) + PAGE_W'(au_pg);

    // Sequencer: next state, result beat and table updates
    always_comb
    begin
        state_next    = state_reg;
        emit          = 1'b0;
        res           = '{op: OP_NONE, target_page: '0, source_page: '0,
                          erase_block: '0, status: STAT_OK, last: 1'b1};
        pw_set_en     = 1'b0;
        pw_set_row    = mb;
        pw_set_col    = off_reg;
        pw_clr_en     = 1'b0;
        map_wr_en     = 1'b0;
        map_set_valid = 1'b0;
        map_wr_val    = new_pbn;
        nxt_inc       = 1'b0;
        spare_wr      = 1'b0;
        latch_ow      = 1'b0;
        latch_sbase   = 1'b0;
        idx_adv       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (ow)
                begin
                    latch_ow   = 1'b1;
                    state_next = S_BASE;
                end
                else if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (range_reg)
                    begin
                        res.status = STAT_RANGE;
                    end
                    else if (!cmd_reg)
                    begin
                        if (mv)
                        begin
                            res.op          = OP_READ;
                            res.target_page = au_addr;
                        end
                        else
                        begin
                            res.status = STAT_UNMAPPED;
                        end
                    end
                    else if (!mv)
                    begin
                        if (32'(nxt_reg) >= PHYS_BLKS)
                        begin
                            res.status = STAT_FULL;
                        end
                        else
                        begin
                            res.op          = OP_PROGRAM;
                            res.target_page = au_addr;
                            pw_set_en       = 1'b1;
                            pw_set_row      = new_pbn;
                            map_wr_en       = 1'b1;
                            map_set_valid   = 1'b1;
                            nxt_inc         = 1'b1;
                        end
                    end
                    else
                    begin
                        res.op          = OP_PROGRAM;
                        res.target_page = au_addr;
                        pw_set_en       = 1'b1;
                    end
                end
            end

            S_BASE:
            begin
                latch_sbase = 1'b1;
                state_next  = S_COPY;
            end

            S_COPY:
            begin
                if (!copy_hit || can_emit)
                begin
                    idx_adv = 1'b1;
                    if (copy_hit)
                    begin
                        emit            = 1'b1;
                        res.op          = OP_COPY;
                        res.target_page = sbase_reg + PAGE_W'(idx_reg);
                        res.source_page = pbase_reg + PAGE_W'(idx_reg);
                        res.last        = 1'b0;
                        pw_set_en       = 1'b1;
                        pw_set_row      = spare_reg;
                        pw_set_col      = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_PROG;
                    end
                end
            end

            S_PROG:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    res.op          = OP_PROGRAM;
                    res.target_page = sbase_reg + PAGE_W'(off_reg);
                    res.last        = 1'b0;
                    pw_set_en       = 1'b1;
                    pw_set_row      = spare_reg;
                    state_next      = S_ERASE;
                end
            end

            S_ERASE:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    res.op          = OP_ERASE;
                    res.erase_block = ERASE_W'(pbn_reg);
                    pw_clr_en       = 1'b1;
                    map_wr_en       = 1'b1;
                    map_wr_val      = spare_reg;
                    spare_wr        = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Update map valid bits, spare block, next unused block and page-written bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= '0;
            pw_reg        <= '0;
            spare_reg     <= '0;
            nxt_reg       <= NXT_W'(1);
        end
        else
        begin
            if (map_set_valid)
            begin
                map_valid_reg[lbn_reg] <= 1'b1;
            end
            if (pw_clr_en)
            begin
                pw_reg[pbn_reg] <= '0;
            end
            if (pw_set_en)
            begin
                pw_reg[pw_set_row][pw_set_col] <= 1'b1;
            end
            if (spare_wr)
            begin
                spare_reg <= pbn_reg;
            end
            if (nxt_inc)
            begin
                nxt_reg <= nxt_reg + NXT_W'(1);
            end
        end
    end

    // Write the block map entries
    always_ff @(posedge clk)
    begin
        if (map_wr_en)
        begin
            map_block_reg[lbn_reg] <= map_wr_val;
        end
    end

    // Capture the request beat and the overwrite walk registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_tuser;
            range_reg <= (32'(s_tdata[SECTOR_W-1:0]) >= 32'(NUM_SECT));
            lbn_reg   <= LBN_TAB[s_tdata[SECTOR_W-1:0]];
            off_reg   <= OFF_TAB[s_tdata[SECTOR_W-1:0]];
        end
        if (latch_ow)
        begin
            pbn_reg   <= mb;
            row_reg   <= mrow;
            pbase_reg <= au_addr;
        end
        if (latch_sbase)
        begin
            sbase_reg <= au_addr;
            idx_reg   <= '0;
        end
        else if (idx_adv)
        begin
            idx_reg <= idx_reg + OFF_W'(1);
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res;
        end
    end

    // Pack the output beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_reg.erase_block, out_reg.source_page,
                       out_reg.target_page};
    assign m_tuser  = {out_reg.status, out_reg.op};
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire

>>> bench/flash_block_map_controller_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the flash block map controller with a map and page-state predictor.

module flash_block_map_controller_tb;
    import fbm_pkg::*;

    localparam int PPB      = DEF_PAGES_PER_BLK;
    localparam int NBLK     = DEF_DATA_BLOCKS;
    localparam int NPHYS    = NBLK + 1;
    localparam int NSECT    = NBLK * PPB;
    localparam int N_RANDOM = 190;
    localparam int DRAIN_MAX = 5000;

    // Predicts the flash commands of each request and checks them in order
    class flash_command_scoreboard;
        bit          blk_mapped[NBLK];
        int unsigned blk_phys[NBLK];
        int unsigned spare_phys;
        int unsigned fresh_phys;
        bit          page_used[NPHYS*PPB];
        result_t     pending_cmds[$];
        int          mismatches;

        function new();
            foreach (blk_mapped[i])
            begin
                blk_mapped[i] = 1'b0;
                blk_phys[i]   = 0;
            end
            foreach (page_used[i])
                page_used[i] = 1'b0;
            spare_phys = 0;
            fresh_phys = 1;
            mismatches = 0;
        endfunction

        function void push_cmd(op_t op, int unsigned tgt, int unsigned src,
                               int unsigned blk, status_t st);
            result_t r;
            r.op          = op;
            r.target_page = tgt[PAGE_W-1:0];
            r.source_page = src[PAGE_W-1:0];
            r.erase_block = blk[ERASE_W-1:0];
            r.status      = st;
            r.last        = 1'b0;
            pending_cmds.push_back(r);
        endfunction

        // Work out the commands of one accepted request and update the map
        function void note_request(bit is_write, logic [SECTOR_W-1:0] sector);
            int unsigned lbn, off, pbn, sp;
            if (int'(sector) >= NSECT)
                push_cmd(OP_NONE, 0, 0, 0, STAT_RANGE);
            else
            begin
                lbn = sector / PPB;
                off = sector % PPB;
                if (!is_write)
                begin
                    if (blk_mapped[lbn])
                        push_cmd(OP_READ, blk_phys[lbn] * PPB + off, 0, 0, STAT_OK);
                    else
                        push_cmd(OP_NONE, 0, 0, 0, STAT_UNMAPPED);
                end
                else if (!blk_mapped[lbn])
                begin
                    if (fresh_phys >= NPHYS)
                        push_cmd(OP_NONE, 0, 0, 0, STAT_FULL);
                    else
                    begin
                        pbn = fresh_phys;
                        push_cmd(OP_PROGRAM, pbn * PPB + off, 0, 0, STAT_OK);
                        page_used[pbn * PPB + off] = 1'b1;
                        blk_phys[lbn]   = pbn;
                        blk_mapped[lbn] = 1'b1;
                        fresh_phys      = pbn + 1;
                    end
                end
                else
                begin
                    pbn = blk_phys[lbn];
                    if (!page_used[pbn * PPB + off])
                    begin
                        push_cmd(OP_PROGRAM, pbn * PPB + off, 0, 0, STAT_OK);
                        page_used[pbn * PPB + off] = 1'b1;
                    end
                    else
                    begin
                        // Overwrite: move the other live pages to the spare, then swap
                        sp = spare_phys;
                        for (int i = 0; i < PPB; i++)
                        begin
                            if (i != off && page_used[pbn * PPB + i])
                            begin
                                push_cmd(OP_COPY, sp * PPB + i, pbn * PPB + i, 0, STAT_OK);
                                page_used[sp * PPB + i] = 1'b1;
                            end
                        end
                        push_cmd(OP_PROGRAM, sp * PPB + off, 0, 0, STAT_OK);
                        page_used[sp * PPB + off] = 1'b1;
                        push_cmd(OP_ERASE, 0, 0, pbn, STAT_OK);
                        for (int i = 0; i < PPB; i++)
                            page_used[pbn * PPB + i] = 1'b0;
                        blk_phys[lbn] = sp;
                        spare_phys    = pbn;
                    end
                end
            end
            pending_cmds[pending_cmds.size() - 1].last = 1'b1;
        endfunction

        function void report(string why, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR %0t: %s exp op=%0d tgt=%0d src=%0d blk=%0d st=%0d last=%0d | got op=%0d tgt=%0d src=%0d blk=%0d st=%0d last=%0d",
                         $time, why, want.op, want.target_page, want.source_page,
                         want.erase_block, want.status, want.last, got.op,
                         got.target_page, got.source_page, got.erase_block,
                         got.status, got.last);
        endfunction

        // Compare one result beat against the oldest expected command
        function void check_command(result_t got);
            result_t want;
            if (pending_cmds.size() == 0)
            begin
                want = '0;
                report("unexpected beat", want, got);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (got.op !== want.op || got.target_page !== want.target_page ||
                    got.source_page !== want.source_page ||
                    got.erase_block !== want.erase_block ||
                    got.status !== want.status || got.last !== want.last)
                    report("command differs", want, got);
            end
        endfunction
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;

    bit                     stall_on = 1'b1;
    flash_command_scoreboard cmd_board = new();

    flash_block_map_controller DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Sample result beats and toggle backpressure
    always @(posedge clk)
    begin : result_sink
        result_t seen;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.op          = op_t'(m_tuser[OP_W-1:0]);
            seen.target_page = m_tdata[PAGE_W-1:0];
            seen.source_page = m_tdata[2*PAGE_W-1:PAGE_W];
            seen.erase_block = m_tdata[2*PAGE_W+ERASE_W-1:2*PAGE_W];
            seen.status      = status_t'(m_tuser[OP_W+STATUS_W-1:OP_W]);
            seen.last        = m_tlast;
            cmd_board.check_command(seen);
        end
        m_tready <= stall_on ? ($urandom_range(0, 99) >= 9) : 1'b1;
    end

    // Present one request beat, with random gaps, and hold it until accepted
    task automatic run_request(input bit is_write, input logic [SECTOR_W-1:0] sector);
        while (stall_on && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-SECTOR_W){1'b0}}, sector};
        s_tuser  <= is_write;
        do
            @(posedge clk);
        while (!s_tready);
        cmd_board.note_request(is_write, sector);
    endtask

    initial
    begin : stimulus
        int unsigned drain;
        int unsigned hot_blk;
        logic [SECTOR_W-1:0] sector;
        bit is_write;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unmapped reads, allocation, fill, overwrites of full and lone pages
        run_request(1'b0, 6'd0);
        run_request(1'b0, 6'd63);
        run_request(1'b1, 6'd0);
        run_request(1'b0, 6'd0);
        run_request(1'b0, 6'd1);
        run_request(1'b1, 6'd1);
        run_request(1'b1, 6'd2);
        run_request(1'b1, 6'd3);
        run_request(1'b1, 6'd0);
        run_request(1'b0, 6'd2);
        run_request(1'b1, 6'd63);
        run_request(1'b1, 6'd63);
        run_request(1'b0, 6'd63);
        run_request(1'b0, 6'd60);
        run_request(1'b1, 6'd62);
        run_request(1'b1, 6'd61);
        run_request(1'b1, 6'd63);
        run_request(1'b1, 6'd20);
        run_request(1'b1, 6'd21);
        run_request(1'b0, 6'd21);
        run_request(1'b1, 6'd1);
        run_request(1'b0, 6'd3);

        // Random: most traffic on a few hot blocks so overwrites of full blocks recur
        for (int n = 0; n < N_RANDOM; n++)
        begin
            stall_on = !(n >= 70 && n < 130);
            if ($urandom_range(0, 99) < 60)
            begin
                hot_blk = $urandom_range(0, 3);
                sector  = SECTOR_W'(hot_blk * PPB + $urandom_range(0, PPB - 1));
            end
            else
                sector = SECTOR_W'($urandom_range(0, NSECT - 1));
            is_write = ($urandom_range(0, 99) < 60);
            run_request(is_write, sector);
        end
        s_tvalid <= 1'b0;
        stall_on = 1'b1;

        // Drain outstanding commands, then watch for strays
        drain = 0;
        while (cmd_board.pending_cmds.size() != 0 && drain < DRAIN_MAX)
        begin
            @(posedge clk);
            drain++;
        end
        if (cmd_board.pending_cmds.size() != 0)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            repeat (3 * (PPB + 6)) @(posedge clk);
            if (cmd_board.mismatches == 0 && cmd_board.pending_cmds.size() == 0)
                $display("No mismatches found");
            else
                $display("Mismatches found");
            $finish;
        end
    end

endmodule
